// ===== rtl/lbcs_pkg.sv =====
// Package for the linked block chain store: sizes, link markers, codes.
// Used by the channel interfaces and by the store itself.
`timescale 1ns / 1ps
package lbcs_pkg;

  localparam int FILE_COUNT      = 32;
  localparam int BLOCK_COUNT     = 64;
  localparam int BYTES_PER_BLOCK = 512;
  localparam int MAX_NAME        = 7;

  localparam int FILE_W  = $clog2(FILE_COUNT);
  localparam int BLOCK_W = $clog2(BLOCK_COUNT);
  localparam int OFF_W   = $clog2(BYTES_PER_BLOCK);
  localparam int LINK_W  = BLOCK_W + 1;
  localparam int BYTE_AW = BLOCK_W + OFF_W;
  localparam int FUNC_W  = 2;
  localparam int POS_W   = 15;
  localparam int SIZE_W  = 16;
  localparam int DATA_W  = 8;
  localparam int STAT_W  = 3;
  localparam int STEP_W  = POS_W - OFF_W;
  localparam int EXTRA_W = SIZE_W + 1 - OFF_W;
  localparam int EXTRA_BIAS = (3 * BYTES_PER_BLOCK) / 4 + BYTES_PER_BLOCK - 1;

  localparam logic [LINK_W-1:0] LINK_FREE = {LINK_W{1'b1}};
  localparam logic [LINK_W-1:0] LINK_END  = {{(LINK_W-1){1'b1}}, 1'b0};

  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
  localparam logic [STAT_W-1:0] ST_NAME   = 3'd1;
  localparam logic [STAT_W-1:0] ST_SPACE  = 3'd2;
  localparam logic [STAT_W-1:0] ST_BROKEN = 3'd3;
  localparam logic [STAT_W-1:0] ST_PAST   = 3'd4;

  typedef struct packed {
    logic [BLOCK_W-1:0] head;
    logic [SIZE_W-1:0]  len;
  } file_entry_t;

endpackage

// ===== rtl/lbcs_in_if.sv =====
// Request channel of the linked block chain store.
// Depends on lbcs_pkg for the field widths.
`timescale 1ns / 1ps
interface lbcs_in_if;
  logic                         valid;
  logic                         ready;
  logic [lbcs_pkg::FUNC_W-1:0]  func;
  logic [lbcs_pkg::FILE_W-1:0]  file_index;
  logic [lbcs_pkg::POS_W-1:0]   byte_pos;
  logic [lbcs_pkg::DATA_W-1:0]  data_byte;
  logic [lbcs_pkg::SIZE_W-1:0]  alloc_size;
  logic [lbcs_pkg::DATA_W-1:0]  name_length;
  modport source (output valid, func, file_index, byte_pos, data_byte, alloc_size,
                  name_length, input ready);
  modport sink (input valid, func, file_index, byte_pos, data_byte, alloc_size,
                name_length, output ready);
endinterface

// ===== rtl/lbcs_out_if.sv =====
// Response channel of the linked block chain store.
// Depends on lbcs_pkg for the field widths.
`timescale 1ns / 1ps
interface lbcs_out_if;
  logic                         valid;
  logic                         ready;
  logic [lbcs_pkg::STAT_W-1:0]  status;
  logic [lbcs_pkg::FILE_W-1:0]  file_index_out;
  logic [lbcs_pkg::DATA_W-1:0]  read_byte;
  logic [lbcs_pkg::SIZE_W-1:0]  file_size;
  modport source (output valid, status, file_index_out, read_byte, file_size,
                  input ready);
  modport sink (input valid, status, file_index_out, read_byte, file_size,
                output ready);
endinterface

// ===== rtl/linked_block_chain_store.sv =====
// Linked block chain store: file entries pointing to chains of data blocks.
// Depends on lbcs_pkg, lbcs_in_if and lbcs_out_if.
//
// After reset the byte memory is cleared one byte a cycle, all
// BLOCK_COUNT * BYTES_PER_BLOCK (32768) bytes; no beat is accepted meanwhile.
// One request is handled at a time, and every block hop is one read of the
// link memory. Allocate writes one link entry per block of the new chain,
// then the file entry. A write that runs past the end of the chain appends
// new blocks to it. A finished result sits in the output register until
// taken; the next beat is accepted in the cycle after the result is loaded
// at the earliest.
`timescale 1ns / 1ps
module linked_block_chain_store (
  input  logic       clk_i,
  input  logic       rst_ni,
  lbcs_in_if.sink    in_i,
  lbcs_out_if.source out_o
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_AFILL = 4'd2;
  localparam logic [3:0] S_FRD   = 4'd3;
  localparam logic [3:0] S_LCHK  = 4'd4;
  localparam logic [3:0] S_APP2  = 4'd5;
  localparam logic [3:0] S_BRD   = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;

  logic [3:0] state_q, state_d;
  logic [lbcs_pkg::FILE_W:0]  fc_q, fc_d;
  logic [lbcs_pkg::BLOCK_W:0] nf_q, nf_d;
  logic [lbcs_pkg::BYTE_AW:0] clr_q, clr_d;
  logic out_valid_q, out_valid_d;

  logic [lbcs_pkg::FUNC_W-1:0]  func_q;
  logic [lbcs_pkg::FILE_W-1:0]  fidx_q;
  logic [lbcs_pkg::POS_W-1:0]   pos_q;
  logic [lbcs_pkg::DATA_W-1:0]  data_q;
  logic [lbcs_pkg::SIZE_W-1:0]  size_q;
  logic [lbcs_pkg::EXTRA_W-1:0] extra_q, extra_d, i_q, i_d;
  logic [lbcs_pkg::BLOCK_W-1:0] base_q, base_d, rb_q, rb_d, head_q, head_d;
  logic [lbcs_pkg::SIZE_W-1:0]  len_q, len_d;
  logic [lbcs_pkg::STEP_W-1:0]  rem_q, rem_d;
  logic endk_q, endk_d;
  logic [lbcs_pkg::STAT_W-1:0]  rs_q, rs_d;
  logic [lbcs_pkg::FILE_W-1:0]  rf_q, rf_d;
  logic [lbcs_pkg::DATA_W-1:0]  rbyte_q, rbyte_d;
  logic [lbcs_pkg::SIZE_W-1:0]  rsize_q, rsize_d;
  logic [lbcs_pkg::STAT_W-1:0]  o_status_q;
  logic [lbcs_pkg::FILE_W-1:0]  o_fidx_q;
  logic [lbcs_pkg::DATA_W-1:0]  o_byte_q;
  logic [lbcs_pkg::SIZE_W-1:0]  o_size_q;

  logic [lbcs_pkg::LINK_W-1:0]  link_mem [lbcs_pkg::BLOCK_COUNT];
  logic                         link_we;
  logic [lbcs_pkg::BLOCK_W-1:0] link_wa, link_ra;
  logic [lbcs_pkg::LINK_W-1:0]  link_wd, link_rd_q;

  lbcs_pkg::file_entry_t        file_mem [lbcs_pkg::FILE_COUNT];
  logic                         file_we;
  logic [lbcs_pkg::FILE_W-1:0]  file_wa, file_ra;
  lbcs_pkg::file_entry_t        file_wd, file_rd_q;

  logic [lbcs_pkg::DATA_W-1:0]  byte_mem [lbcs_pkg::BLOCK_COUNT * lbcs_pkg::BYTES_PER_BLOCK];
  logic                         byte_we;
  logic [lbcs_pkg::BYTE_AW-1:0] byte_wa, byte_ra;
  logic [lbcs_pkg::DATA_W-1:0]  byte_wd, byte_rd_q;

  logic accept, load_out, fin_go;
  logic [lbcs_pkg::BLOCK_W-1:0] fin_rb;
  logic [lbcs_pkg::SIZE_W:0]    extra_sum;
  logic [lbcs_pkg::EXTRA_W-1:0] extra_in;
  logic [lbcs_pkg::EXTRA_W+1:0] need;
  logic [lbcs_pkg::LINK_W-1:0]  nx;
  logic [lbcs_pkg::SIZE_W-1:0]  pos_ext;

  assign accept   = in_i.valid && in_i.ready;
  assign load_out = (state_q == S_FIN) && (!out_valid_q || out_o.ready);
  assign in_i.ready = (state_q == S_IDLE);

  assign extra_sum = {1'b0, in_i.alloc_size} + (lbcs_pkg::SIZE_W+1)'(lbcs_pkg::EXTRA_BIAS);
  assign extra_in  = (in_i.alloc_size > lbcs_pkg::SIZE_W'(lbcs_pkg::BYTES_PER_BLOCK)) ?
                     extra_sum[lbcs_pkg::SIZE_W:lbcs_pkg::OFF_W] : '0;
  assign need      = (lbcs_pkg::EXTRA_W+2)'(nf_q) + (lbcs_pkg::EXTRA_W+2)'(extra_in) + 1'b1;
  assign nx        = endk_q ? lbcs_pkg::LINK_END : link_rd_q;
  assign pos_ext   = {1'b0, pos_q};

  always_comb begin
    state_d = state_q; fc_d = fc_q; nf_d = nf_q; clr_d = clr_q;
    extra_d = extra_q; i_d = i_q; base_d = base_q; rb_d = rb_q; head_d = head_q;
    len_d = len_q; rem_d = rem_q; endk_d = endk_q;
    rs_d = rs_q; rf_d = rf_q; rbyte_d = rbyte_q; rsize_d = rsize_q;
    link_we = 1'b0; link_wa = rb_q; link_wd = lbcs_pkg::LINK_END; link_ra = rb_q;
    file_we = 1'b0; file_wa = fidx_q; file_wd = '{head: head_q, len: len_q};
    file_ra = fidx_q;
    byte_we = 1'b0; byte_wa = {rb_q, pos_q[lbcs_pkg::OFF_W-1:0]}; byte_wd = data_q;
    byte_ra = {rb_q, pos_q[lbcs_pkg::OFF_W-1:0]};
    fin_go = 1'b0; fin_rb = rb_q;
    case (state_q)
      S_CLEAR: begin
        byte_we = 1'b1;
        byte_wa = clr_q[lbcs_pkg::BYTE_AW-1:0];
        byte_wd = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q[lbcs_pkg::BYTE_AW-1:0] == {lbcs_pkg::BYTE_AW{1'b1}}) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        file_ra = in_i.file_index;
        if (accept) begin
          rs_d = lbcs_pkg::ST_OK; rf_d = '0; rbyte_d = '0; rsize_d = '0;
          state_d = S_FIN;
          if (in_i.func == lbcs_pkg::FUNC_ALLOC) begin
            if (in_i.name_length > lbcs_pkg::DATA_W'(lbcs_pkg::MAX_NAME)) begin
              rs_d = lbcs_pkg::ST_NAME;
            end else if (fc_q == (lbcs_pkg::FILE_W+1)'(lbcs_pkg::FILE_COUNT) ||
                         need > (lbcs_pkg::EXTRA_W+2)'(lbcs_pkg::BLOCK_COUNT)) begin
              rs_d = lbcs_pkg::ST_SPACE;
            end else begin
              extra_d = extra_in;
              i_d = '0;
              base_d = nf_q[lbcs_pkg::BLOCK_W-1:0];
              state_d = S_AFILL;
            end
          end else if (in_i.func == lbcs_pkg::FUNC_READ ||
                       in_i.func == lbcs_pkg::FUNC_WRITE) begin
            if ({1'b0, in_i.file_index} >= fc_q) begin
              rs_d = lbcs_pkg::ST_BROKEN;
            end else begin
              state_d = S_FRD;
            end
          end
        end
      end
      S_AFILL: begin
        link_we = 1'b1;
        link_wa = lbcs_pkg::BLOCK_W'(base_q + i_q);
        link_wd = (i_q == extra_q) ? lbcs_pkg::LINK_END :
                  lbcs_pkg::LINK_W'(base_q + i_q + 1'b1);
        i_d = i_q + 1'b1;
        if (i_q == extra_q) begin
          file_we = 1'b1;
          file_wa = fc_q[lbcs_pkg::FILE_W-1:0];
          file_wd = '{head: base_q, len: size_q};
          fc_d = fc_q + 1'b1;
          nf_d = nf_q + (lbcs_pkg::BLOCK_W+1)'(extra_q) + 1'b1;
          rf_d = fc_q[lbcs_pkg::FILE_W-1:0];
          rsize_d = size_q;
          state_d = S_FIN;
        end
      end
      S_FRD: begin
        head_d = file_rd_q.head;
        len_d = file_rd_q.len;
        rb_d = file_rd_q.head;
        rem_d = pos_q[lbcs_pkg::POS_W-1:lbcs_pkg::OFF_W];
        endk_d = 1'b0;
        if (pos_q[lbcs_pkg::POS_W-1:lbcs_pkg::OFF_W] == '0) begin
          fin_go = 1'b1;
          fin_rb = file_rd_q.head;
        end else begin
          link_ra = file_rd_q.head;
          state_d = S_LCHK;
        end
      end
      S_LCHK: begin
        rem_d = rem_q - 1'b1;
        endk_d = 1'b0;
        if (nx == lbcs_pkg::LINK_FREE) begin
          rs_d = lbcs_pkg::ST_BROKEN; rsize_d = len_q; state_d = S_FIN;
        end else if (nx == lbcs_pkg::LINK_END) begin
          rsize_d = len_q;
          if (func_q != lbcs_pkg::FUNC_WRITE) begin
            rs_d = lbcs_pkg::ST_PAST; state_d = S_FIN;
          end else if (nf_q == (lbcs_pkg::BLOCK_W+1)'(lbcs_pkg::BLOCK_COUNT)) begin
            rs_d = lbcs_pkg::ST_SPACE; state_d = S_FIN;
          end else begin
            link_we = 1'b1;
            link_wa = rb_q;
            link_wd = lbcs_pkg::LINK_W'(nf_q);
            state_d = S_APP2;
          end
        end else begin
          rb_d = nx[lbcs_pkg::BLOCK_W-1:0];
          if (rem_q == lbcs_pkg::STEP_W'(1)) begin
            fin_go = 1'b1;
            fin_rb = nx[lbcs_pkg::BLOCK_W-1:0];
          end else begin
            link_ra = nx[lbcs_pkg::BLOCK_W-1:0];
          end
        end
      end
      S_APP2: begin
        link_we = 1'b1;
        link_wa = nf_q[lbcs_pkg::BLOCK_W-1:0];
        link_wd = lbcs_pkg::LINK_END;
        nf_d = nf_q + 1'b1;
        rb_d = nf_q[lbcs_pkg::BLOCK_W-1:0];
        if (rem_q == '0) begin
          fin_go = 1'b1;
          fin_rb = nf_q[lbcs_pkg::BLOCK_W-1:0];
        end else begin
          endk_d = 1'b1;
          state_d = S_LCHK;
        end
      end
      S_BRD: begin
        rbyte_d = byte_rd_q;
        rsize_d = len_q;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (fin_go) begin
      byte_wa = {fin_rb, pos_q[lbcs_pkg::OFF_W-1:0]};
      byte_ra = {fin_rb, pos_q[lbcs_pkg::OFF_W-1:0]};
      if (func_q == lbcs_pkg::FUNC_WRITE) begin
        byte_we = 1'b1;
        file_we = 1'b1;
        file_wd.head = head_d;
        file_wd.len = (pos_ext >= len_d) ? pos_ext + 1'b1 : len_d;
        rsize_d = file_wd.len;
        state_d = S_FIN;
      end else begin
        state_d = S_BRD;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      fc_q <= '0;
      nf_q <= '0;
      clr_q <= '0;
      out_valid_q <= 1'b0;
      endk_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fc_q <= fc_d;
      nf_q <= nf_d;
      clr_q <= clr_d;
      out_valid_q <= out_valid_d;
      endk_q <= endk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= in_i.func;
      fidx_q <= in_i.file_index;
      pos_q <= in_i.byte_pos;
      data_q <= in_i.data_byte;
      size_q <= in_i.alloc_size;
    end
    extra_q <= extra_d; i_q <= i_d; base_q <= base_d; rb_q <= rb_d;
    head_q <= head_d; len_q <= len_d; rem_q <= rem_d;
    rs_q <= rs_d; rf_q <= rf_d; rbyte_q <= rbyte_d; rsize_q <= rsize_d;
    if (load_out) begin
      o_status_q <= rs_q;
      o_fidx_q <= rf_q;
      o_byte_q <= rbyte_q;
      o_size_q <= rsize_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_rd_q <= link_mem[link_ra];
  end

  always_ff @(posedge clk_i) begin
    if (file_we) begin
      file_mem[file_wa] <= file_wd;
    end
    file_rd_q <= file_mem[file_ra];
  end

  always_ff @(posedge clk_i) begin
    if (byte_we) begin
      byte_mem[byte_wa] <= byte_wd;
    end
    byte_rd_q <= byte_mem[byte_ra];
  end

  assign out_o.valid = out_valid_q;
  assign out_o.status = o_status_q;
  assign out_o.file_index_out = o_fidx_q;
  assign out_o.read_byte = o_byte_q;
  assign out_o.file_size = o_size_q;

  a_fc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= (lbcs_pkg::FILE_W+1)'(lbcs_pkg::FILE_COUNT))
    else $error("File count exceeds the number of entries.");

  a_nf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nf_q <= (lbcs_pkg::BLOCK_W+1)'(lbcs_pkg::BLOCK_COUNT))
    else $error("Block fill count exceeds the number of blocks.");

  a_nf_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> nf_q >= $past(nf_q))
    else $error("Block fill count went down.");

  a_byte_in_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_we && state_q != S_CLEAR) |->
      {1'b0, byte_wa[lbcs_pkg::BYTE_AW-1:lbcs_pkg::OFF_W]} < nf_d)
    else $error("Byte write lands in an unallocated block.");

endmodule
